// ===== design/vgdr_pkg.sv =====
// Shared constants, command codes and types of the visibility grid disc reveal core.
`default_nettype none
package vgdr_pkg;

   // Store geometry and radius format.
   localparam int MAX_WIDTH        = 128;
   localparam int MAX_HEIGHT       = 128;
   localparam int RADIUS_FRAC_BITS = 4;

   // Field widths fixed by the item format.
   localparam int OP_BITS      = 3;
   localparam int COORD_BITS   = 9;
   localparam int STATE_BITS   = 2;
   localparam int RADIUS_BITS  = 12;
   localparam int DIM_REG_BITS = 8;

   // Bit positions of the request fields inside req_tdata.
   localparam int OP_LSB     = 0;
   localparam int X_LSB      = OP_LSB + OP_BITS;
   localparam int Y_LSB      = X_LSB + COORD_BITS;
   localparam int VAL_LSB    = Y_LSB + COORD_BITS;
   localparam int RADIUS_LSB = VAL_LSB + STATE_BITS;
   localparam int REQ_FIELD_BITS = RADIUS_LSB + RADIUS_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   // Derived widths of coordinates, addresses and distance terms.
   localparam int X_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int XY_BITS   = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
   localparam int DIFF_BITS = ((XY_BITS > COORD_BITS) ? XY_BITS : COORD_BITS) + 2;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int CMP_BITS  = SQ_BITS + 1 + 2 * RADIUS_FRAC_BITS;
   localparam int RSQ_BITS  = 2 * RADIUS_BITS;
   localparam int CLIP_BITS = RADIUS_BITS + 3;

   // Configuration register indexes and reset value.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 1'b1;
   localparam logic [DIM_REG_BITS-1:0]   GRID_DIM_RESET  = 8'd128;

   // Command opcodes.
   localparam logic [OP_BITS-1:0] OP_WRITE      = 3'd0;
   localparam logic [OP_BITS-1:0] OP_READ       = 3'd1;
   localparam logic [OP_BITS-1:0] OP_AGE        = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DISC       = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd4;
   localparam logic [OP_BITS-1:0] OP_REVEAL_ALL = 3'd5;

   // Cell state codes.
   localparam logic [STATE_BITS-1:0] ST_UNSEEN   = 2'd0;
   localparam logic [STATE_BITS-1:0] ST_REVEALED = 2'd1;
   localparam logic [STATE_BITS-1:0] ST_VISIBLE  = 2'd2;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // A classified command as the back executes it.
   typedef struct packed {
      logic [OP_BITS-1:0]           op;
      logic                         in_grid;
      logic [ADDR_BITS-1:0]         addr;
      logic [STATE_BITS-1:0]        val;
      logic [X_BITS-1:0]            x0;
      logic [X_BITS-1:0]            x1;
      logic [Y_BITS-1:0]            y0;
      logic [Y_BITS-1:0]            y1;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic [RSQ_BITS-1:0]          rsq;
      logic [W_BITS-1:0]            width;
   } cmd_type;

   // Fill status of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== design/vgdr_front.sv =====
// Front end: configuration registers, request decode, grid clipping and command push.
`default_nettype none
module vgdr_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [vgdr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [vgdr_pkg::DIM_REG_BITS-1:0]     csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [vgdr_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  wire logic                                  init_done,
   input  wire vgdr_pkg::queue_status_type            q_stat,
   output logic                                       push,
   output vgdr_pkg::cmd_type                          push_cmd
);

   localparam int CB = vgdr_pkg::CLIP_BITS;
   localparam int CW = vgdr_pkg::COORD_BITS;
   localparam int RB = vgdr_pkg::RADIUS_BITS;

   logic [vgdr_pkg::DIM_REG_BITS-1:0] grid_width_ff, grid_width_in;
   logic [vgdr_pkg::DIM_REG_BITS-1:0] grid_height_ff, grid_height_in;

   logic [vgdr_pkg::OP_BITS-1:0]     op;
   logic signed [CW-1:0]             cx, cy;
   logic [vgdr_pkg::STATE_BITS-1:0]  val;
   logic [RB-1:0]                    radius;

   logic signed [CB-1:0] w_eff, h_eff, cx_s, cy_s, ri_s;
   logic signed [CB-1:0] x0_raw, x1_raw, y0_raw, y1_raw;
   logic signed [CB-1:0] x0_c, x1_c, y0_c, y1_c;
   logic [RB:0]          ri;
   logic                 in_grid, disc_empty, keep;
   logic [vgdr_pkg::ADDR_BITS-1:0] y_a, w_a, x_a, cell_addr;
   logic [vgdr_pkg::RSQ_BITS-1:0]  r_ext, rsq;

   // Configuration writes.
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            vgdr_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            vgdr_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= vgdr_pkg::GRID_DIM_RESET;
         grid_height_ff <= vgdr_pkg::GRID_DIM_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // Effective grid size: zero acts as one, anything above the store size is clamped.
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = CB'(1);
      end else if (32'(grid_width_ff) > vgdr_pkg::MAX_WIDTH) begin
         w_eff = CB'(vgdr_pkg::MAX_WIDTH);
      end else begin
         w_eff = CB'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         h_eff = CB'(1);
      end else if (32'(grid_height_ff) > vgdr_pkg::MAX_HEIGHT) begin
         h_eff = CB'(vgdr_pkg::MAX_HEIGHT);
      end else begin
         h_eff = CB'(grid_height_ff);
      end
   end

   // Request fields.
   assign op     = req_tdata[vgdr_pkg::OP_LSB +: vgdr_pkg::OP_BITS];
   assign cx     = req_tdata[vgdr_pkg::X_LSB +: CW];
   assign cy     = req_tdata[vgdr_pkg::Y_LSB +: CW];
   assign val    = req_tdata[vgdr_pkg::VAL_LSB +: vgdr_pkg::STATE_BITS];
   assign radius = req_tdata[vgdr_pkg::RADIUS_LSB +: RB];

   assign cx_s = {{(CB-CW){cx[CW-1]}}, cx};
   assign cy_s = {{(CB-CW){cy[CW-1]}}, cy};

   // Single-cell grid check and linear address y*width + x.
   assign in_grid = (cx_s >= 0) && (cx_s < w_eff) && (cy_s >= 0) && (cy_s < h_eff);
   assign y_a = {{(vgdr_pkg::ADDR_BITS-vgdr_pkg::Y_BITS){1'b0}}, cy_s[vgdr_pkg::Y_BITS-1:0]};
   assign x_a = {{(vgdr_pkg::ADDR_BITS-vgdr_pkg::X_BITS){1'b0}}, cx_s[vgdr_pkg::X_BITS-1:0]};
   assign w_a = {{(vgdr_pkg::ADDR_BITS-vgdr_pkg::W_BITS){1'b0}}, w_eff[vgdr_pkg::W_BITS-1:0]};
   assign cell_addr = y_a * w_a + x_a;

   // Disc bounding box: whole-cell radius rounded up, clipped to the grid.
   assign ri     = ({1'b0, radius} + (RB+1)'((1 << vgdr_pkg::RADIUS_FRAC_BITS) - 1))
                   >> vgdr_pkg::RADIUS_FRAC_BITS;
   assign ri_s   = {{(CB-RB-1){1'b0}}, ri};
   assign x0_raw = cx_s - ri_s;
   assign x1_raw = cx_s + ri_s;
   assign y0_raw = cy_s - ri_s;
   assign y1_raw = cy_s + ri_s;
   assign x0_c   = (x0_raw < 0) ? '0 : x0_raw;
   assign y0_c   = (y0_raw < 0) ? '0 : y0_raw;
   assign x1_c   = (x1_raw > w_eff - CB'(1)) ? w_eff - CB'(1) : x1_raw;
   assign y1_c   = (y1_raw > h_eff - CB'(1)) ? h_eff - CB'(1) : y1_raw;
   assign disc_empty = (x0_c > x1_c) || (y0_c > y1_c);

   // Squared radius for the exact distance test.
   assign r_ext = {{(vgdr_pkg::RSQ_BITS-RB){1'b0}}, radius};
   assign rsq   = r_ext * r_ext;

   // Commands with no effect are dropped here and never reach the back.
   always_comb begin
      unique case (op)
         vgdr_pkg::OP_WRITE:      keep = in_grid;
         vgdr_pkg::OP_READ:       keep = 1'b1;
         vgdr_pkg::OP_AGE:        keep = 1'b1;
         vgdr_pkg::OP_DISC:       keep = !disc_empty;
         vgdr_pkg::OP_CLEAR:      keep = 1'b1;
         vgdr_pkg::OP_REVEAL_ALL: keep = 1'b1;
         default:                 keep = 1'b0;
      endcase
   end

   assign req_tready = init_done && !q_stat.full;
   assign push       = req_tvalid && req_tready && keep;

   always_comb begin
      push_cmd.op      = op;
      push_cmd.in_grid = in_grid;
      push_cmd.addr    = cell_addr;
      push_cmd.val     = val;
      push_cmd.x0      = x0_c[vgdr_pkg::X_BITS-1:0];
      push_cmd.x1      = x1_c[vgdr_pkg::X_BITS-1:0];
      push_cmd.y0      = y0_c[vgdr_pkg::Y_BITS-1:0];
      push_cmd.y1      = y1_c[vgdr_pkg::Y_BITS-1:0];
      push_cmd.cx      = cx;
      push_cmd.cy      = cy;
      push_cmd.rsq     = rsq;
      push_cmd.width   = w_eff[vgdr_pkg::W_BITS-1:0];
   end

endmodule
`default_nettype wire

// ===== design/vgdr_queue.sv =====
// Short command queue that decouples the front end from the grid sequencer.
`default_nettype none
module vgdr_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire vgdr_pkg::cmd_type          push_cmd,
   input  wire logic                       pop,
   output vgdr_pkg::cmd_type               head,
   output vgdr_pkg::queue_status_type      q_stat
);

   vgdr_pkg::cmd_type entry_ff [vgdr_pkg::QUEUE_DEPTH];

   logic [vgdr_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vgdr_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vgdr_pkg::QCNT_BITS-1:0] count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == vgdr_pkg::QCNT_BITS'(vgdr_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== design/vgdr_back.sv =====
// Back end: cell store, sweep and disc scan sequencer, and the response register.
`default_nettype none
module vgdr_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire vgdr_pkg::cmd_type                     head,
   input  wire vgdr_pkg::queue_status_type            q_stat,
   output logic                                       pop,
   output logic                                       init_done,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [vgdr_pkg::RSP_DATA_BITS-1:0]         rsp_tdata
);

   localparam int AB = vgdr_pkg::ADDR_BITS;
   localparam int DB = vgdr_pkg::DIFF_BITS;
   localparam int SB = vgdr_pkg::SQ_BITS;
   localparam int XB = vgdr_pkg::X_BITS;
   localparam int YB = vgdr_pkg::Y_BITS;
   localparam int CW = vgdr_pkg::COORD_BITS;
   localparam int KB = vgdr_pkg::CMP_BITS;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_AGE  = 3'd3;
   localparam logic [2:0] S_DSET = 3'd4;
   localparam logic [2:0] S_DISC = 3'd5;
   localparam logic [2:0] S_READ = 3'd6;

   localparam logic [AB-1:0] LAST_CELL = AB'(vgdr_pkg::CELLS - 1);

   // Cell store: one write and one registered read per cycle.
   logic [vgdr_pkg::STATE_BITS-1:0] cell_mem [vgdr_pkg::CELLS];

   logic [2:0]                       state_ff, state_in;
   logic [AB-1:0]                    cnt_ff, cnt_in;
   logic [vgdr_pkg::STATE_BITS-1:0]  fill_val_ff, fill_val_in;
   vgdr_pkg::cmd_type                cmd_ff, cmd_in;
   logic [XB-1:0]                    sx_ff, sx_in;
   logic [YB-1:0]                    sy_ff, sy_in;
   logic [AB-1:0]                    row_ff, row_in;
   logic                             age_v_ff, age_v_in;
   logic [AB-1:0]                    age_addr_ff, age_addr_in;
   logic                             disc_v_ff, disc_v_in;
   logic [AB-1:0]                    disc_addr_ff, disc_addr_in;
   logic [SB-1:0]                    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vgdr_pkg::STATE_BITS-1:0]  rsp_state_ff, rsp_state_in;
   logic [vgdr_pkg::STATE_BITS-1:0]  mem_q_ff;

   logic                             mem_we, mem_re;
   logic [AB-1:0]                    mem_waddr, mem_raddr;
   logic [vgdr_pkg::STATE_BITS-1:0]  mem_wdata;

   logic                             pipes_empty, rsp_free, can_start;
   logic signed [DB-1:0]             dx, dy;
   logic [DB-1:0]                    adx, ady;
   logic [SB-1:0]                    adx_w, ady_w;
   logic [SB:0]                      dist_sq;
   logic [KB-1:0]                    dist_cmp, rsq_cmp;
   logic                             disc_hit;

   // Start a new command only once all earlier store writes have landed.
   assign pipes_empty = !age_v_ff && !disc_v_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign can_start   = (state_ff == S_IDLE) && !q_stat.empty && pipes_empty
                        && ((head.op != vgdr_pkg::OP_READ) || rsp_free);
   assign pop         = can_start;
   assign init_done   = (state_ff != S_INIT);

   // Distance of the scanned cell from the disc centre.
   assign dx  = {{(DB-XB){1'b0}}, sx_ff} - {{(DB-CW){cmd_ff.cx[CW-1]}}, cmd_ff.cx};
   assign dy  = {{(DB-YB){1'b0}}, sy_ff} - {{(DB-CW){cmd_ff.cy[CW-1]}}, cmd_ff.cy};
   assign adx = (dx < 0) ? DB'(-dx) : DB'(dx);
   assign ady = (dy < 0) ? DB'(-dy) : DB'(dy);
   assign adx_w = {{(SB-DB){1'b0}}, adx};
   assign ady_w = {{(SB-DB){1'b0}}, ady};

   // Exact test of the registered squares against the squared radius.
   assign dist_sq  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign dist_cmp = KB'(dist_sq) << (2 * vgdr_pkg::RADIUS_FRAC_BITS);
   assign rsq_cmp  = KB'(cmd_ff.rsq);
   assign disc_hit = (dist_cmp <= rsq_cmp);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_val_in  = fill_val_ff;
      cmd_in       = cmd_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      row_in       = row_ff;
      age_v_in     = 1'b0;
      age_addr_in  = age_addr_ff;
      disc_v_in    = 1'b0;
      disc_addr_in = disc_addr_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_state_in = rsp_state_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = vgdr_pkg::ST_UNSEEN;
      mem_re       = 1'b0;
      mem_raddr    = cnt_ff;

      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = vgdr_pkg::ST_UNSEEN;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (can_start) begin
               cmd_in = head;
               unique case (head.op)
                  vgdr_pkg::OP_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = head.addr;
                     mem_wdata = head.val;
                  end
                  vgdr_pkg::OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = head.addr;
                     state_in  = S_READ;
                  end
                  vgdr_pkg::OP_AGE: begin
                     cnt_in   = '0;
                     state_in = S_AGE;
                  end
                  vgdr_pkg::OP_DISC: begin
                     state_in = S_DSET;
                  end
                  vgdr_pkg::OP_CLEAR: begin
                     cnt_in      = '0;
                     fill_val_in = vgdr_pkg::ST_UNSEEN;
                     state_in    = S_FILL;
                  end
                  vgdr_pkg::OP_REVEAL_ALL: begin
                     cnt_in      = '0;
                     fill_val_in = vgdr_pkg::ST_REVEALED;
                     state_in    = S_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = fill_val_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_AGE: begin
            mem_re      = 1'b1;
            mem_raddr   = cnt_ff;
            age_v_in    = 1'b1;
            age_addr_in = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_DSET: begin
            row_in   = {{(AB-YB){1'b0}}, cmd_ff.y0}
                       * {{(AB-vgdr_pkg::W_BITS){1'b0}}, cmd_ff.width};
            sx_in    = cmd_ff.x0;
            sy_in    = cmd_ff.y0;
            state_in = S_DISC;
         end
         S_DISC: begin
            disc_v_in    = 1'b1;
            disc_addr_in = row_ff + {{(AB-XB){1'b0}}, sx_ff};
            sqx_in       = adx_w * adx_w;
            sqy_in       = ady_w * ady_w;
            if (sx_ff == cmd_ff.x1) begin
               sx_in = cmd_ff.x0;
               if (sy_ff == cmd_ff.y1) begin
                  state_in = S_IDLE;
               end else begin
                  sy_in  = sy_ff + 1'b1;
                  row_in = row_ff + {{(AB-vgdr_pkg::W_BITS){1'b0}}, cmd_ff.width};
               end
            end else begin
               sx_in = sx_ff + 1'b1;
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_state_in = cmd_ff.in_grid ? mem_q_ff : vgdr_pkg::ST_UNSEEN;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Age write-back in the cycle after its read.
      if (age_v_ff && (mem_q_ff == vgdr_pkg::ST_VISIBLE)) begin
         mem_we    = 1'b1;
         mem_waddr = age_addr_ff;
         mem_wdata = vgdr_pkg::ST_REVEALED;
      end

      // Disc write in the cycle after its scan step.
      if (disc_v_ff && disc_hit) begin
         mem_we    = 1'b1;
         mem_waddr = disc_addr_ff;
         mem_wdata = vgdr_pkg::ST_VISIBLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         age_v_ff     <= 1'b0;
         disc_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         age_v_ff     <= age_v_in;
         disc_v_ff    <= disc_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      fill_val_ff  <= fill_val_in;
      cmd_ff       <= cmd_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      row_ff       <= row_in;
      age_addr_ff  <= age_addr_in;
      disc_addr_ff <= disc_addr_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      rsp_state_ff <= rsp_state_in;
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Store read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_q_ff <= cell_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(vgdr_pkg::RSP_DATA_BITS-vgdr_pkg::STATE_BITS){1'b0}}, rsp_state_ff};

endmodule
`default_nettype wire

// ===== design/visibility_grid_disc_reveal_core.sv =====
// In the back end a write goes to the store as the command is taken; a read's item passes the registered
// store read and the response register. A disc is scanned over its clipped box after a setup state, one cell per cycle.
// Age, clear and reveal-all each sweep all 16384 store entries, one store entry per cycle.
// A four-entry command queue lets the front keep accepting items while the back is busy.
// After reset a clearing pass writes unseen to all 16384 entries; req_tready stays low meanwhile.
// Reset is synchronous and active high; grid width and height reset to 128.
`default_nettype none
module visibility_grid_disc_reveal_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration write port.
   input  wire logic                                  csr_we,
   input  wire logic [vgdr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [vgdr_pkg::DIM_REG_BITS-1:0]     csr_wdata,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata from bit 0: opcode[3], cell_x[9], cell_y[9], state_value[2], radius[12], zero fill.
   input  wire logic [vgdr_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Response channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata from bit 0: cell_state[2], zero fill.
   output logic [vgdr_pkg::RSP_DATA_BITS-1:0]         rsp_tdata
);

   logic                       q_push, q_pop, init_done;
   vgdr_pkg::cmd_type          push_cmd, q_head;
   vgdr_pkg::queue_status_type q_stat;

   // Front end: decode and clip.
   vgdr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .init_done  (init_done),
      .q_stat     (q_stat),
      .push       (q_push),
      .push_cmd   (push_cmd)
   );

   // Command queue.
   vgdr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .q_stat   (q_stat)
   );

   // Back end: store and sequencer.
   vgdr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_stat     (q_stat),
      .pop        (q_pop),
      .init_done  (init_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   // The queue is never pushed when full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("command pushed into a full queue");

   // The back never takes a command from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("command popped from an empty queue");

   // No response can appear while the clearing pass after reset runs.
   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !rsp_tvalid)
      else $error("response during the clearing pass");

   // No item is taken in before the store is cleared.
   a_no_push_in_init: assert property (@(posedge clock) disable iff (reset)
      q_push |-> init_done)
      else $error("command queued during the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== bench/visibility_grid_disc_reveal_core_tb.sv =====
// Self-checking testbench: directed and random grid commands checked against a cell-state predictor.
module visibility_grid_disc_reveal_core_tb;
   import vgdr_pkg::*;

   // Opcodes the block ignores, and the state code with no special meaning.
   localparam logic [OP_BITS-1:0]    OP_RESERVED_6 = 3'd6;
   localparam logic [OP_BITS-1:0]    OP_RESERVED_7 = 3'd7;
   localparam logic [STATE_BITS-1:0] ST_SPARE      = 2'd3;

   localparam int NO_FIXED       = -1;
   localparam int DIRECTED_ROWS  = 27;
   localparam int RANDOM_ITEMS   = 1200;
   localparam int PHASE_COUNT    = 7;
   localparam int RECENT_DEPTH   = 16;
   localparam int MAX_REPORTS    = 10;
   // One whole-store pass of the back end plus a margin.
   localparam int DRAIN_CYCLES   = CELLS + 16;
   // Four queued whole-store passes behind a read, plus the clearing pass, several times over.
   localparam int WATCHDOG_LIMIT = 300000;

   typedef struct {
      logic [OP_BITS-1:0]           op;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic [STATE_BITS-1:0]        val;
      logic [RADIUS_BITS-1:0]       radius;
   } grid_command_type;

   typedef struct {
      int op;
      int x;
      int y;
      int val;
      int radius;
      int fixed_state;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DIM_REG_BITS-1:0]   csr_wdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   // Predicted grid contents and register copies.
   logic [STATE_BITS-1:0]   predicted_cells [CELLS];
   logic [DIM_REG_BITS-1:0] grid_width_reg  = GRID_DIM_RESET;
   logic [DIM_REG_BITS-1:0] grid_height_reg = GRID_DIM_RESET;

   logic [STATE_BITS-1:0]        expected_cell_states [$];
   logic [STATE_BITS-1:0]        expected_state;
   logic signed [COORD_BITS-1:0] recent_x [$];
   logic signed [COORD_BITS-1:0] recent_y [$];

   int error_count    = 0;
   int rsp_stall_left = 0;
   int stalled_cycles = 0;
   bit quiet_stretch  = 1'b0;

   int phase_sizes [PHASE_COUNT][2] = '{
      '{0, 255}, '{255, 0}, '{1, 1}, '{129, 3}, '{7, 128}, '{23, 61}, '{128, 128}
   };

   // Directed items: extremes, every opcode and the corner cases of the grid and the disc.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_READ,          0,    0, 0,     0, ST_UNSEEN},
      '{OP_READ,        127,  127, 0,     0, ST_UNSEEN},
      '{OP_WRITE,         0,    0, 3,     0, NO_FIXED},
      '{OP_WRITE,       127,  127, 2,     0, NO_FIXED},
      // Writes just outside the grid are dropped.
      '{OP_WRITE,        -1,    5, 1,     0, NO_FIXED},
      '{OP_WRITE,       128,    0, 1,  4095, NO_FIXED},
      '{OP_READ,          0,    0, 0,     0, ST_SPARE},
      '{OP_READ,       -256, -256, 3,  4095, ST_UNSEEN},
      // Aging turns visible into revealed and leaves the spare code alone.
      '{OP_AGE,           0,    0, 0,     0, NO_FIXED},
      '{OP_READ,        127,  127, 0,     0, ST_REVEALED},
      '{OP_READ,          0,    0, 0,     0, ST_SPARE},
      // A zero radius marks the center cell only.
      '{OP_DISC,         10,   10, 0,     0, NO_FIXED},
      '{OP_READ,         10,   10, 0,     0, ST_VISIBLE},
      '{OP_READ,         11,   10, 0,     0, NO_FIXED},
      // Disc clipped at the grid corner.
      '{OP_DISC,         -3,   -3, 0,  'h50, NO_FIXED},
      '{OP_READ,          1,    0, 0,     0, NO_FIXED},
      // Disc lying wholly outside the grid.
      '{OP_DISC,       -200,   50, 0, 'h100, NO_FIXED},
      // Radius of one and a half cells.
      '{OP_DISC,         64,   64, 0,  'h18, NO_FIXED},
      '{OP_READ,         65,   65, 0,     0, NO_FIXED},
      '{OP_READ,         66,   64, 0,     0, NO_FIXED},
      '{OP_RESERVED_6,  127,  127, 3,  4095, NO_FIXED},
      '{OP_RESERVED_7, -256,  255, 2,     1, NO_FIXED},
      // Largest radius from the far corner of the coordinate range.
      '{OP_DISC,        255,  255, 0,  4095, NO_FIXED},
      '{OP_REVEAL_ALL,    0,    0, 0,     0, NO_FIXED},
      '{OP_READ,          5,    5, 0,     0, ST_REVEALED},
      '{OP_CLEAR,         0,    0, 0,     0, NO_FIXED},
      '{OP_READ,        127,  127, 0,     0, ST_UNSEEN}
   };

   visibility_grid_disc_reveal_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register value as the block uses it: zero acts as one, and large values saturate.
   function automatic int clamp_dim(input logic [DIM_REG_BITS-1:0] value, input int limit);
      int dim;
      dim = int'(value);
      if (dim < 1) dim = 1;
      if (dim > limit) dim = limit;
      return dim;
   endfunction

   // Updates the predicted grid for one command; returns 1 when the command yields a cell state.
   function automatic bit apply_grid_command(input grid_command_type cmd,
                                             output logic [STATE_BITS-1:0] read_state);
      int     width_eff;
      int     height_eff;
      int     cx;
      int     cy;
      int     reach;
      int     x_lo;
      int     x_hi;
      int     y_lo;
      int     y_hi;
      longint disc_bound;
      longint dist_sq;
      bit     in_bounds;
      width_eff  = clamp_dim(grid_width_reg, MAX_WIDTH);
      height_eff = clamp_dim(grid_height_reg, MAX_HEIGHT);
      cx = int'(cmd.cx);
      cy = int'(cmd.cy);
      in_bounds = cx >= 0 && cx < width_eff && cy >= 0 && cy < height_eff;
      read_state = ST_UNSEEN;
      case (cmd.op)
         OP_WRITE: begin
            if (in_bounds) predicted_cells[cy * width_eff + cx] = cmd.val;
         end
         OP_READ: begin
            if (in_bounds) read_state = predicted_cells[cy * width_eff + cx];
            return 1'b1;
         end
         OP_AGE: begin
            foreach (predicted_cells[i])
               if (predicted_cells[i] == ST_VISIBLE) predicted_cells[i] = ST_REVEALED;
         end
         OP_DISC: begin
            // Exact test in fixed point; the scan box is ceil(radius) around the center.
            disc_bound = longint'(cmd.radius) * longint'(cmd.radius);
            reach = (int'(cmd.radius) + (1 << RADIUS_FRAC_BITS) - 1) >> RADIUS_FRAC_BITS;
            x_lo = (cx - reach < 0) ? 0 : cx - reach;
            y_lo = (cy - reach < 0) ? 0 : cy - reach;
            x_hi = (cx + reach > width_eff - 1) ? width_eff - 1 : cx + reach;
            y_hi = (cy + reach > height_eff - 1) ? height_eff - 1 : cy + reach;
            for (int y = y_lo; y <= y_hi; y++) begin
               for (int x = x_lo; x <= x_hi; x++) begin
                  dist_sq = longint'(x - cx) * longint'(x - cx)
                            + longint'(y - cy) * longint'(y - cy);
                  if ((dist_sq << (2 * RADIUS_FRAC_BITS)) <= disc_bound)
                     predicted_cells[y * width_eff + x] = ST_VISIBLE;
               end
            end
         end
         OP_CLEAR: begin
            foreach (predicted_cells[i]) predicted_cells[i] = ST_UNSEEN;
         end
         OP_REVEAL_ALL: begin
            foreach (predicted_cells[i]) predicted_cells[i] = ST_REVEALED;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offers one item, waits for its acceptance and records the state it should read back.
   task automatic send_command(input grid_command_type cmd, input int fixed_state);
      int                    gap;
      logic [STATE_BITS-1:0] read_state;
      gap = (quiet_stretch || $urandom_range(0, 99) < 50) ? 0 : pick_idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_DATA_BITS'({cmd.radius, cmd.val, cmd.cy, cmd.cx, cmd.op});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (apply_grid_command(cmd, read_state))
         expected_cell_states.push_back(
            (fixed_state == NO_FIXED) ? read_state : STATE_BITS'(fixed_state));
   endtask

   // Waits for every outstanding read, then lets the back end finish any whole-store pass.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_cell_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: random back-pressure and comparison with the oldest expected state.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cell_states.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected response: cell_state %0d with no read outstanding",
                           rsp_tdata[STATE_BITS-1:0]);
            end else begin
               expected_state = expected_cell_states.pop_front();
               if (rsp_tdata[STATE_BITS-1:0] !== expected_state) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("cell_state mismatch: expected %0d, got %0d",
                              expected_state, rsp_tdata[STATE_BITS-1:0]);
               end
            end
         end
         if (rsp_stall_left != 0) begin
            rsp_tready     <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else if (!quiet_stretch && $urandom_range(0, 99) < 20) begin
            rsp_tready     <= 1'b0;
            rsp_stall_left <= pick_idle_length() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Stimulus: directed table at reset size, then random phases over several grid sizes.
   initial begin : stimulus
      grid_command_type cmd;
      int               per_phase;
      int               counted;
      int               pick;
      int               slot;
      int               width_eff;
      int               height_eff;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_GRID_WIDTH;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      foreach (predicted_cells[i]) predicted_cells[i] = ST_UNSEEN;
      per_phase = RANDOM_ITEMS / PHASE_COUNT;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         cmd.op     = OP_BITS'(directed_rows[i].op);
         cmd.cx     = COORD_BITS'(directed_rows[i].x);
         cmd.cy     = COORD_BITS'(directed_rows[i].y);
         cmd.val    = STATE_BITS'(directed_rows[i].val);
         cmd.radius = RADIUS_BITS'(directed_rows[i].radius);
         send_command(cmd, directed_rows[i].fixed_state);
      end
      settle_block();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Resize the grid while the block is idle; both registers in back-to-back cycles.
         csr_we    <= 1'b1;
         csr_index <= CSR_GRID_WIDTH;
         csr_wdata <= DIM_REG_BITS'(phase_sizes[phase][0]);
         @(posedge clock);
         csr_index <= CSR_GRID_HEIGHT;
         csr_wdata <= DIM_REG_BITS'(phase_sizes[phase][1]);
         @(posedge clock);
         csr_we <= 1'b0;
         grid_width_reg  = DIM_REG_BITS'(phase_sizes[phase][0]);
         grid_height_reg = DIM_REG_BITS'(phase_sizes[phase][1]);
         width_eff  = clamp_dim(grid_width_reg, MAX_WIDTH);
         height_eff = clamp_dim(grid_height_reg, MAX_HEIGHT);

         counted = 0;
         while (counted < per_phase) begin
            if (counted % 64 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);

            // Whole-store commands are kept rare: each one costs a full pass over the store.
            pick = $urandom_range(0, 999);
            if (pick < 320)      cmd.op = OP_WRITE;
            else if (pick < 670) cmd.op = OP_READ;
            else if (pick < 945) cmd.op = OP_DISC;
            else if (pick < 955) cmd.op = OP_AGE;
            else if (pick < 960) cmd.op = OP_CLEAR;
            else if (pick < 965) cmd.op = OP_REVEAL_ALL;
            else if (pick < 982) cmd.op = OP_RESERVED_6;
            else                 cmd.op = OP_RESERVED_7;

            // Coordinates mostly in and just around the grid, sometimes anywhere.
            if ($urandom_range(0, 99) < 12) begin
               cmd.cx = COORD_BITS'($urandom);
               cmd.cy = COORD_BITS'($urandom);
            end else begin
               cmd.cx = COORD_BITS'(int'($urandom_range(0, width_eff + 3)) - 2);
               cmd.cy = COORD_BITS'(int'($urandom_range(0, height_eff + 3)) - 2);
            end
            // Many reads revisit recently written cells.
            if (cmd.op == OP_READ && recent_x.size() != 0 && $urandom_range(0, 99) < 45) begin
               slot   = $urandom_range(0, recent_x.size() - 1);
               cmd.cx = recent_x[slot];
               cmd.cy = recent_y[slot];
            end
            if (cmd.op == OP_WRITE) begin
               recent_x.push_back(cmd.cx);
               recent_y.push_back(cmd.cy);
               if (recent_x.size() > RECENT_DEPTH) begin
                  void'(recent_x.pop_front());
                  void'(recent_y.pop_front());
               end
            end
            cmd.val = STATE_BITS'($urandom_range(0, 3));

            // Small radii dominate; the full range appears now and then.
            pick = $urandom_range(0, 99);
            if (pick < 75)      cmd.radius = RADIUS_BITS'($urandom_range(0, 64));
            else if (pick < 97) cmd.radius = RADIUS_BITS'($urandom_range(0, 255));
            else                cmd.radius = RADIUS_BITS'($urandom_range(0, 4095));

            send_command(cmd, NO_FIXED);
            if (cmd.op != OP_RESERVED_6 && cmd.op != OP_RESERVED_7) counted++;
         end

         // A closing read: its response proves that every earlier command has been carried out.
         quiet_stretch = 1'b0;
         cmd.op     = OP_READ;
         cmd.cx     = '0;
         cmd.cy     = '0;
         cmd.val    = ST_UNSEEN;
         cmd.radius = '0;
         send_command(cmd, NO_FIXED);
         settle_block();
      end

      if (error_count == 0 && expected_cell_states.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== visibility_grid_disc_reveal_core.f =====
design/vgdr_pkg.sv
design/vgdr_front.sv
design/vgdr_queue.sv
design/vgdr_back.sv
design/visibility_grid_disc_reveal_core.sv
bench/visibility_grid_disc_reveal_core_tb.sv
